### hdl/csc_pkg.sv
package csc_pkg;

    // Field widths of one word on either channel.
    localparam int XW   = 24;
    localparam int AZW  = 17;
    localparam int ELW  = 16;
    localparam int RADW = 24;

    // CORDIC datapath and angle accumulator (1/65536 degree) widths.
    localparam int CW      = 36;
    localparam int ANGW    = 26;
    localparam int TAB_LEN = 24;

    typedef logic signed [CW-1:0]   t_cord;
    typedef logic signed [ANGW-1:0] t_ang;

    localparam t_ang  DEG90  = 26'sd5898240;
    localparam t_cord KINV   = 36'sd652032874;

    // Angle limits in 1/256 degree.
    localparam logic signed [17:0] AZ_MAX  = 18'sd46080;
    localparam logic signed [17:0] EL_MAX  = 18'sd23040;
    localparam logic signed [17:0] AZ_FULL = 18'sd92160;

    // atan(2^-i) in 1/65536 degree.
    localparam t_ang ATAN_TAB [TAB_LEN] = '{
        26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
        26'sd234379,  26'sd117304,  26'sd58666,  26'sd29335,
        26'sd14668,   26'sd7334,    26'sd3667,   26'sd1833,
        26'sd917,     26'sd458,     26'sd229,    26'sd115,
        26'sd57,      26'sd29,      26'sd14,     26'sd7,
        26'sd4,       26'sd2,       26'sd1,      26'sd0
    };

endpackage

### hdl/csc_ifs.sv
interface csc_req_if;
    logic                               valid;
    logic                               ready;
    logic                               action;
    logic signed [csc_pkg::XW-1:0]      coord_x;
    logic signed [csc_pkg::XW-1:0]      coord_y;
    logic signed [csc_pkg::XW-1:0]      coord_z;
    logic signed [csc_pkg::AZW-1:0]     azimuth_in;
    logic signed [csc_pkg::ELW-1:0]     elevation_in;
    logic        [csc_pkg::RADW-1:0]    radius_in;

    modport source (output valid, action, coord_x, coord_y, coord_z, azimuth_in,
                    elevation_in, radius_in, input ready);
    modport sink   (input valid, action, coord_x, coord_y, coord_z, azimuth_in,
                    elevation_in, radius_in, output ready);
endinterface

interface csc_rsp_if;
    logic                               valid;
    logic                               ready;
    logic signed [csc_pkg::XW-1:0]      x_out;
    logic signed [csc_pkg::XW-1:0]      y_out;
    logic signed [csc_pkg::XW-1:0]      z_out;
    logic signed [csc_pkg::AZW-1:0]     azimuth_out;
    logic signed [csc_pkg::ELW-1:0]     elevation_out;
    logic        [csc_pkg::RADW-1:0]    radius_out;
    logic                               saturated;

    modport source (output valid, x_out, y_out, z_out, azimuth_out, elevation_out,
                    radius_out, saturated, input ready);
    modport sink   (input valid, x_out, y_out, z_out, azimuth_out, elevation_out,
                    radius_out, saturated, output ready);
endinterface

### hdl/cartesian_spherical_converter.sv
// Throughput: one word per cycle; the pipeline stalls as a whole only while a result waits.
// The path is a square stage, a sum stage, two 24-stage square roots, a setup stage, the
// CORDIC stages, a post stage, three multiply stages and an output stage.
// Reset (synchronous, active low) clears only the valid bits; data registers are not reset.
module cartesian_spherical_converter #(
    parameter int CORDIC_STAGES = 16,
    parameter int COORD_BITS    = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    csc_req_if.sink       i_req,
    csc_rsp_if.source     o_rsp
);
    localparam int SQ  = 24;
    localparam int LAT = CORDIC_STAGES + 32;
    localparam logic signed [58:0] SAT_HI = (59'sd1 <<< (COORD_BITS - 1)) - 59'sd1;
    localparam logic signed [58:0] SAT_LO = -SAT_HI - 59'sd1;

    typedef struct packed {
        logic                    act;
        logic signed [23:0]      x;
        logic signed [23:0]      y;
        logic signed [23:0]      z;
        logic signed [16:0]      az;
        logic signed [15:0]      el;
        logic        [23:0]      r;
    } t_side;

    typedef struct packed {
        logic                    act;
        logic                    a_spec;
        logic signed [17:0]      a_val;
        logic                    e_spec;
        logic signed [17:0]      e_val;
        logic                    neg_a;
        logic                    neg_e;
        logic        [23:0]      rad;
        logic        [23:0]      r;
    } t_mid;

    typedef struct packed {
        logic                    act;
        logic signed [16:0]      az;
        logic signed [15:0]      el;
        logic        [23:0]      rad;
        logic        [23:0]      r;
    } t_tail;

    logic [LAT-1:0] r_vld;
    logic           w_en;

    assign w_en        = !r_vld[LAT-1] || o_rsp.ready;
    assign i_req.ready = w_en;
    assign o_rsp.valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_req.valid};
        end
    end

    // Stage 1: squares and azimuth wrap.
    logic signed [47:0] w_xx, w_yy, w_zz;
    logic signed [17:0] w_az18;
    logic signed [17:0] w_azw;
    logic        [47:0] r1_xx, r1_yy, r1_zz;
    t_side              r1_side;

    assign w_xx   = i_req.coord_x * i_req.coord_x;
    assign w_yy   = i_req.coord_y * i_req.coord_y;
    assign w_zz   = i_req.coord_z * i_req.coord_z;
    assign w_az18 = 18'(i_req.azimuth_in);

    always_comb begin
        if (w_az18 >= csc_pkg::AZ_MAX) begin
            w_azw = w_az18 - csc_pkg::AZ_FULL;
        end else if (w_az18 < -csc_pkg::AZ_MAX) begin
            w_azw = w_az18 + csc_pkg::AZ_FULL;
        end else begin
            w_azw = w_az18;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_xx        <= w_xx;
            r1_yy        <= w_yy;
            r1_zz        <= w_zz;
            r1_side.act  <= i_req.action;
            r1_side.x    <= i_req.coord_x;
            r1_side.y    <= i_req.coord_y;
            r1_side.z    <= i_req.coord_z;
            r1_side.az   <= 17'(w_azw);
            r1_side.el   <= i_req.elevation_in;
            r1_side.r    <= i_req.radius_in;
        end
    end

    // Stage 2: horizontal and full squared lengths.
    logic [47:0] r2_h2, r2_h3;
    t_side       r2_side;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_h2   <= r1_xx + r1_yy;
            r2_h3   <= r1_xx + r1_yy + r1_zz;
            r2_side <= r1_side;
        end
    end

    // Square roots, with the rest of the word carried alongside.
    logic [23:0] w_root2, w_root3;
    logic [48:0] w_rem2, w_rem3;
    t_side       r_sd [SQ];

    csc_isqrt u_sqrt_h (
        .i_clk (i_clk), .i_en (w_en), .i_val (r2_h2), .o_root (w_root2), .o_rem (w_rem2)
    );
    csc_isqrt u_sqrt_r (
        .i_clk (i_clk), .i_en (w_en), .i_val (r2_h3), .o_root (w_root3), .o_rem (w_rem3)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sd[0] <= r2_side;
            for (int k = 1; k < SQ; k++) begin
                r_sd[k] <= r_sd[k-1];
            end
        end
    end

    // Prep stage: round the roots and set up both CORDIC lanes.
    t_side              sd;
    logic [24:0]        w_gd, w_rad;
    csc_pkg::t_cord     w_x256, w_y256, w_z256;
    logic signed [17:0] w_fa, w_fe;
    logic               n_va, n_vb;
    csc_pkg::t_cord     n_aa, n_ba, n_ab, n_bb;
    csc_pkg::t_ang      n_acca, n_accb;
    t_mid               n_mid;
    logic               r3_va, r3_vb;
    csc_pkg::t_cord     r3_aa, r3_ba, r3_ab, r3_bb;
    csc_pkg::t_ang      r3_acca, r3_accb;
    t_mid               r3_mid;

    assign sd     = r_sd[SQ-1];
    assign w_gd   = {1'b0, w_root2} + {24'b0, (w_rem2 > {25'b0, w_root2})};
    assign w_rad  = {1'b0, w_root3} + {24'b0, (w_rem3 > {25'b0, w_root3})};
    assign w_x256 = csc_pkg::t_cord'(sd.x) <<< 8;
    assign w_y256 = csc_pkg::t_cord'(sd.y) <<< 8;
    assign w_z256 = csc_pkg::t_cord'(sd.z) <<< 8;

    always_comb begin
        n_va   = 1'b1;
        n_vb   = 1'b1;
        n_aa   = w_y256;
        n_ba   = w_x256;
        n_acca = '0;
        n_ab   = csc_pkg::t_cord'({11'b0, w_gd}) <<< 8;
        n_bb   = w_z256;
        n_accb = '0;
        w_fa   = 18'(sd.az);
        w_fe   = 18'(sd.el);
        n_mid  = '0;
        n_mid.act = sd.act;
        n_mid.r   = sd.r;
        if (!sd.act) begin
            n_mid.rad = w_rad[24] ? 24'hFFFFFF : w_rad[23:0];
            // Bring the azimuth vector into the right half plane first.
            if (sd.y < 0) begin
                if (sd.x >= 0) begin
                    n_aa   = w_x256;
                    n_ba   = -w_y256;
                    n_acca = csc_pkg::DEG90;
                end else begin
                    n_aa   = -w_x256;
                    n_ba   = w_y256;
                    n_acca = -csc_pkg::DEG90;
                end
            end
            if (sd.x == 0) begin
                n_mid.a_spec = 1'b1;
                n_mid.a_val  = (sd.y < 0) ? csc_pkg::AZ_MAX : 18'sd0;
            end else if (sd.y == 0) begin
                n_mid.a_spec = 1'b1;
                n_mid.a_val  = (sd.x > 0) ? csc_pkg::EL_MAX : -csc_pkg::EL_MAX;
            end
            if (sd.z == 0) begin
                n_mid.e_spec = 1'b1;
                n_mid.e_val  = 18'sd0;
            end else if (sd.x == 0 && sd.y == 0) begin
                n_mid.e_spec = 1'b1;
                n_mid.e_val  = (sd.z > 0) ? csc_pkg::EL_MAX : -csc_pkg::EL_MAX;
            end
        end else begin
            // Angles past a quarter turn are folded by a half turn, with sin and cos negated.
            if (w_fa > csc_pkg::EL_MAX) begin
                w_fa = w_fa - csc_pkg::AZ_MAX;
                n_mid.neg_a = 1'b1;
            end else if (w_fa < -csc_pkg::EL_MAX) begin
                w_fa = w_fa + csc_pkg::AZ_MAX;
                n_mid.neg_a = 1'b1;
            end
            if (w_fe > csc_pkg::EL_MAX) begin
                w_fe = w_fe - csc_pkg::AZ_MAX;
                n_mid.neg_e = 1'b1;
            end else if (w_fe < -csc_pkg::EL_MAX) begin
                w_fe = w_fe + csc_pkg::AZ_MAX;
                n_mid.neg_e = 1'b1;
            end
            n_va   = 1'b0;
            n_vb   = 1'b0;
            n_aa   = csc_pkg::KINV;
            n_ba   = '0;
            n_ab   = csc_pkg::KINV;
            n_bb   = '0;
            n_acca = csc_pkg::t_ang'(w_fa) <<< 8;
            n_accb = csc_pkg::t_ang'(w_fe) <<< 8;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_va   <= n_va;
            r3_vb   <= n_vb;
            r3_aa   <= n_aa;
            r3_ba   <= n_ba;
            r3_acca <= n_acca;
            r3_ab   <= n_ab;
            r3_bb   <= n_bb;
            r3_accb <= n_accb;
            r3_mid  <= n_mid;
        end
    end

    // CORDIC lanes: azimuth and elevation.
    csc_pkg::t_cord w_oaa, w_oba, w_oab, w_obb;
    csc_pkg::t_ang  w_oacca, w_oaccb;
    t_mid           r_md [CORDIC_STAGES];

    csc_cordic #(.STAGES (CORDIC_STAGES)) u_cordic_az (
        .i_clk (i_clk), .i_en (w_en), .i_vect (r3_va),
        .i_a (r3_aa), .i_b (r3_ba), .i_acc (r3_acca),
        .o_a (w_oaa), .o_b (w_oba), .o_acc (w_oacca)
    );
    csc_cordic #(.STAGES (CORDIC_STAGES)) u_cordic_el (
        .i_clk (i_clk), .i_en (w_en), .i_vect (r3_vb),
        .i_a (r3_ab), .i_b (r3_bb), .i_acc (r3_accb),
        .o_a (w_oab), .o_b (w_obb), .o_acc (w_oaccb)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_md[0] <= r3_mid;
            for (int k = 1; k < CORDIC_STAGES; k++) begin
                r_md[k] <= r_md[k-1];
            end
        end
    end

    // Post stage: round and clamp angles, apply the fold sign to sin and cos.
    t_mid               md;
    csc_pkg::t_ang      w_anga, w_ange;
    logic signed [17:0] w_aza, w_ele;
    csc_pkg::t_cord     w_ca, w_sa, w_ce, w_se;
    logic signed [31:0] r4_ca, r4_sa, r4_ce, r4_se;
    t_tail              r4_tail;

    assign md     = r_md[CORDIC_STAGES-1];
    assign w_anga = (w_oacca + 26'sd128) >>> 8;
    assign w_ange = (w_oaccb + 26'sd128) >>> 8;
    assign w_ca   = md.neg_a ? -w_oaa : w_oaa;
    assign w_sa   = md.neg_a ? -w_oba : w_oba;
    assign w_ce   = md.neg_e ? -w_oab : w_oab;
    assign w_se   = md.neg_e ? -w_obb : w_obb;

    always_comb begin
        if (md.a_spec) begin
            w_aza = md.a_val;
        end else if (w_anga > 26'sd46080) begin
            w_aza = csc_pkg::AZ_MAX;
        end else if (w_anga < -26'sd46080) begin
            w_aza = -csc_pkg::AZ_MAX;
        end else begin
            w_aza = 18'(w_anga);
        end
        if (md.e_spec) begin
            w_ele = md.e_val;
        end else if (w_ange > 26'sd23040) begin
            w_ele = csc_pkg::EL_MAX;
        end else if (w_ange < -26'sd23040) begin
            w_ele = -csc_pkg::EL_MAX;
        end else begin
            w_ele = 18'(w_ange);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_ca       <= 32'(w_ca);
            r4_sa       <= 32'(w_sa);
            r4_ce       <= 32'(w_ce);
            r4_se       <= 32'(w_se);
            r4_tail.act <= md.act;
            r4_tail.az  <= 17'(w_aza);
            r4_tail.el  <= 16'(w_ele);
            r4_tail.rad <= md.rad;
            r4_tail.r   <= md.r;
        end
    end

    // Multiply stages: direction vector, then scale by radius.
    logic signed [63:0] r5_p0, r5_p1;
    logic signed [31:0] r5_se;
    t_tail              r5_tail;
    logic signed [33:0] r6_v [3];
    t_tail              r6_tail;
    logic signed [58:0] r7_q [3];
    t_tail              r7_tail;
    logic signed [24:0] w_r;

    assign w_r = signed'({1'b0, r6_tail.r});

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_p0   <= r4_sa * r4_ce;
            r5_p1   <= r4_ca * r4_ce;
            r5_se   <= r4_se;
            r5_tail <= r4_tail;
            r6_v[0] <= 34'((r5_p0 + 64'sd536870912) >>> 30);
            r6_v[1] <= 34'((r5_p1 + 64'sd536870912) >>> 30);
            r6_v[2] <= 34'(r5_se);
            r6_tail <= r5_tail;
            for (int k = 0; k < 3; k++) begin
                r7_q[k] <= r6_v[k] * w_r;
            end
            r7_tail <= r6_tail;
        end
    end

    // Output stage: round, saturate and zero the fields the action leaves unused.
    logic signed [58:0] w_p   [3];
    logic signed [58:0] w_cl  [3];
    logic        [2:0]  w_sat;
    logic signed [23:0] r_x, r_y, r_z;
    logic signed [16:0] r_az;
    logic signed [15:0] r_el;
    logic        [23:0] r_rad;
    logic               r_sat;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_p[k]   = (r7_q[k] + 59'sd536870912) >>> 30;
            w_sat[k] = (w_p[k] > SAT_HI) || (w_p[k] < SAT_LO);
            if (w_p[k] > SAT_HI) begin
                w_cl[k] = SAT_HI;
            end else if (w_p[k] < SAT_LO) begin
                w_cl[k] = SAT_LO;
            end else begin
                w_cl[k] = w_p[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r7_tail.act) begin
                r_x   <= 24'(w_cl[0]);
                r_y   <= 24'(w_cl[1]);
                r_z   <= 24'(w_cl[2]);
                r_sat <= |w_sat;
                r_az  <= '0;
                r_el  <= '0;
                r_rad <= '0;
            end else begin
                r_x   <= '0;
                r_y   <= '0;
                r_z   <= '0;
                r_sat <= 1'b0;
                r_az  <= r7_tail.az;
                r_el  <= r7_tail.el;
                r_rad <= r7_tail.rad;
            end
        end
    end

    assign o_rsp.x_out         = r_x;
    assign o_rsp.y_out         = r_y;
    assign o_rsp.z_out         = r_z;
    assign o_rsp.azimuth_out   = r_az;
    assign o_rsp.elevation_out = r_el;
    assign o_rsp.radius_out    = r_rad;
    assign o_rsp.saturated     = r_sat;
endmodule

### hdl/csc_isqrt.sv
module csc_isqrt (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [47:0] i_val,
    output logic [23:0] o_root,
    output logic [48:0] o_rem
);
    localparam int RTW = 24;
    localparam int RMW = 49;

    logic [RTW-1:0] r_root [RTW];
    logic [RMW-1:0] r_rem  [RTW];

    // One root bit per stage, most significant first; the remainder is n - root^2.
    for (genvar k = 0; k < RTW; k++) begin : g_stage
        localparam int J = RTW - 1 - k;
        logic [RTW-1:0] root_in;
        logic [RMW-1:0] rem_in;
        logic [RMW-1:0] trial;

        if (k == 0) begin : g_first
            assign root_in = '0;
            assign rem_in  = {1'b0, i_val};
        end else begin : g_next
            assign root_in = r_root[k-1];
            assign rem_in  = r_rem[k-1];
        end

        assign trial = ({{(RMW-RTW){1'b0}}, root_in} << (J + 1)) + (RMW'(1) << (2 * J));

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (rem_in >= trial) begin
                    r_rem[k]  <= rem_in - trial;
                    r_root[k] <= root_in | (RTW'(1) << J);
                end else begin
                    r_rem[k]  <= rem_in;
                    r_root[k] <= root_in;
                end
            end
        end
    end

    assign o_root = r_root[RTW-1];
    assign o_rem  = r_rem[RTW-1];
endmodule

### hdl/csc_cordic.sv
module csc_cordic #(
    parameter int STAGES = 16
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic           i_vect,
    input  csc_pkg::t_cord i_a,
    input  csc_pkg::t_cord i_b,
    input  csc_pkg::t_ang  i_acc,
    output csc_pkg::t_cord o_a,
    output csc_pkg::t_cord o_b,
    output csc_pkg::t_ang  o_acc
);
    logic           r_vect [STAGES];
    csc_pkg::t_cord r_a    [STAGES];
    csc_pkg::t_cord r_b    [STAGES];
    csc_pkg::t_ang  r_acc  [STAGES];

    // Vectoring drives b toward zero; rotation drives the residual angle toward zero.
    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        logic           vect_in;
        csc_pkg::t_cord a_in, b_in, da, db, n_a, n_b;
        csc_pkg::t_ang  acc_in, n_acc;
        logic           dn;

        if (k == 0) begin : g_first
            assign vect_in = i_vect;
            assign a_in    = i_a;
            assign b_in    = i_b;
            assign acc_in  = i_acc;
        end else begin : g_next
            assign vect_in = r_vect[k-1];
            assign a_in    = r_a[k-1];
            assign b_in    = r_b[k-1];
            assign acc_in  = r_acc[k-1];
        end

        assign da    = b_in >>> k;
        assign db    = a_in >>> k;
        assign dn    = vect_in ? b_in[csc_pkg::CW-1] : !acc_in[csc_pkg::ANGW-1];
        assign n_a   = dn ? a_in - da : a_in + da;
        assign n_b   = dn ? b_in + db : b_in - db;
        assign n_acc = dn ? acc_in - csc_pkg::ATAN_TAB[k] : acc_in + csc_pkg::ATAN_TAB[k];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_vect[k] <= vect_in;
                r_a[k]    <= n_a;
                r_b[k]    <= n_b;
                r_acc[k]  <= n_acc;
            end
        end
    end

    assign o_a   = r_a[STAGES-1];
    assign o_b   = r_b[STAGES-1];
    assign o_acc = r_acc[STAGES-1];
endmodule
